/* hdl/huffman_code_bit_packer_core_assert.svh */
// Assertion macros shared by the Huffman bit packer checkers
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define HCBP_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define HCBP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hcbp_pkg.sv */
// Shared constants and types of the Huffman bit packer
package hcbp_pkg;

    localparam int MODE_W     = 2;
    localparam int SYM_W      = 8;
    localparam int WORD_W     = 32;
    localparam int LEN_IN_W   = 6;
    localparam int BYTE_W     = 8;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINAL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Entries of the queue between lookup and packing
    localparam int QUEUE_DEPTH = 4;

    // Queue fill status seen by the front end
    typedef struct packed {
        logic full;
        logic one_left;
    } hcbp_qstat_t;

endpackage

/* hdl/hcbp_if.sv */
// Valid/ready channel interfaces for symbols in and packed bytes out
interface hcbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [hcbp_pkg::MODE_W-1:0]   mode;
    logic [hcbp_pkg::SYM_W-1:0]    symbol;
    logic [hcbp_pkg::WORD_W-1:0]   code_word;
    logic [hcbp_pkg::LEN_IN_W-1:0] code_length;

    modport source (output valid, mode, symbol, code_word, code_length, input ready);
    modport sink   (input valid, mode, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
    logic                        valid;
    logic                        ready;
    logic [hcbp_pkg::BYTE_W-1:0] out_byte;
    logic                        last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

/* hdl/hcbp_ram.sv */
// Generic single-write, single-read RAM with registered read data
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/hcbp_front.sv */
// Front end: accept items, write the code table, look up codes to encode
module hcbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    hcbp_in_if.sink                                     symbol_ch,
    input  hcbp_pkg::hcbp_qstat_t                       qstat,
    output logic                                        push,
    output logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1):0] push_entry
);
    import hcbp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int AW     = $clog2(SYMBOL_COUNT);
    localparam int DATA_W = MAX_CODE_LEN + LEN_W;

    logic                    accept;
    logic                    in_range;
    logic                    is_encode;
    logic [AW-1:0]           addr;
    logic [LEN_W-1:0]        len_sat;
    logic [MAX_CODE_LEN-1:0] code_mask;
    logic [2*WORD_W-1:0]     word_wide;
    logic [MAX_CODE_LEN-1:0] code_masked;
    logic                    table_we;
    logic [DATA_W-1:0]       table_rdata;
    logic [SYMBOL_COUNT-1:0] loaded_reg;
    logic                    s1_valid_reg;
    logic                    s1_last_reg;
    logic                    s1_hit_reg;
    logic [MAX_CODE_LEN-1:0] hit_code;
    logic [LEN_W-1:0]        hit_len;

    // Hold input while the queue may not take the item in flight
    assign symbol_ch.ready = !qstat.full && !(qstat.one_left && s1_valid_reg);
    assign accept          = symbol_ch.valid && symbol_ch.ready;

    // Classify the transaction
    assign in_range  = int'(symbol_ch.symbol) < SYMBOL_COUNT;
    assign addr      = symbol_ch.symbol[AW-1:0];
    assign is_encode = (symbol_ch.mode == MODE_ENCODE) || (symbol_ch.mode == MODE_FINAL);
    assign table_we  = accept && (symbol_ch.mode == MODE_LOAD) && in_range;

    // Saturate the length and drop code bits above it
    assign len_sat = (int'(symbol_ch.code_length) > MAX_CODE_LEN) ?
                     LEN_W'(MAX_CODE_LEN) : symbol_ch.code_length[LEN_W-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_CODE_LEN; i++)
        begin
            code_mask[i] = i < int'(len_sat);
        end
    end

    assign word_wide   = {{WORD_W{1'b0}}, symbol_ch.code_word};
    assign code_masked = word_wide[MAX_CODE_LEN-1:0] & code_mask;

    // Code table: code word above length
    hcbp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (addr),
        .wdata ({code_masked, len_sat}),
        .raddr (addr),
        .rdata (table_rdata)
    );

    // Track loaded entries; an unloaded entry reads as zero length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (table_we)
        begin
            loaded_reg[addr] <= 1'b1;
        end
    end

    // Lookup stage alongside the table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && is_encode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= symbol_ch.mode == MODE_FINAL;
            s1_hit_reg  <= in_range && loaded_reg[addr];
        end
    end

    // Push the looked-up code into the queue
    assign hit_code   = s1_hit_reg ? table_rdata[DATA_W-1:LEN_W] : '0;
    assign hit_len    = s1_hit_reg ? table_rdata[LEN_W-1:0] : '0;
    assign push       = s1_valid_reg;
    assign push_entry = {s1_last_reg, hit_len, hit_code};

endmodule

/* hdl/hcbp_queue.sv */
// Short FIFO between code lookup and bit packing
module hcbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data,
    output hcbp_pkg::hcbp_qstat_t qstat
);
    import hcbp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    assign qstat.full     = count_reg == CW'(DEPTH);
    assign qstat.one_left = count_reg == CW'(DEPTH - 1);

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/hcbp_back.sv */
// Back end: append codes to the bit accumulator and emit packed bytes
module hcbp_back #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  logic [MAX_CODE_LEN-1:0]          head_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] head_len,
    input  logic                             head_last,
    output logic                             pop,
    hcbp_out_if.source                       byte_ch
);
    import hcbp_pkg::*;

    localparam int ACC_W = MAX_CODE_LEN + BYTE_W - 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pad_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              has_full;
    logic              emit_full;
    logic              emit_pad;
    logic [CNT_W-1:0]  cnt_left;
    logic [ACC_W-1:0]  shifted;
    logic [BYTE_W-1:0] full_byte;
    logic [3:0]        pad_amt;
    logic [BYTE_W-1:0] pad_byte;
    logic              full_last;
    logic [CNT_W-1:0]  cnt_after;
    logic              pad_after;
    logic [ACC_W-1:0]  acc_merged;
    logic [CNT_W-1:0]  cnt_merged;

    // Byte selection from the accumulator
    assign out_free  = !out_valid_reg || byte_ch.ready;
    assign has_full  = cnt_reg >= CNT_W'(BYTE_W);
    assign emit_full = has_full && out_free;
    assign emit_pad  = !has_full && (cnt_reg != '0) && pad_reg && out_free;
    assign cnt_left  = cnt_reg - CNT_W'(BYTE_W);
    assign shifted   = acc_reg >> cnt_left;
    assign full_byte = shifted[BYTE_W-1:0];
    assign pad_amt   = 4'(BYTE_W) - {1'b0, cnt_reg[2:0]};
    assign pad_byte  = acc_reg[BYTE_W-1:0] << pad_amt;

    // A full byte closes its run when no more full bytes and no pad byte follow
    assign full_last = (cnt_left < CNT_W'(BYTE_W)) && !(pad_reg && (cnt_left != '0));

    // Accumulator after this cycle's emission
    assign cnt_after = emit_full ? cnt_left : (emit_pad ? '0 : cnt_reg);
    assign pad_after = pad_reg && !(emit_pad || (cnt_reg == '0) ||
                                    (emit_full && (cnt_left == '0)));

    // Take the next code once fewer than a byte of bits remain and no pad byte is pending
    assign pop        = head_valid && (cnt_after < CNT_W'(BYTE_W)) && !pad_after;
    assign acc_merged = (acc_reg << head_len) | ACC_W'(head_code);
    assign cnt_merged = cnt_after + CNT_W'(head_len);

    // Accumulator payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            acc_reg <= acc_merged;
        end
    end

    // Accumulator control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pad_reg <= 1'b0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_merged;
            pad_reg <= head_last;
        end
        else
        begin
            cnt_reg <= cnt_after;
            pad_reg <= pad_after;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit_full || emit_pad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_byte_reg <= emit_full ? full_byte : pad_byte;
            out_last_reg <= emit_full ? full_last : 1'b1;
        end
    end

    assign byte_ch.valid       = out_valid_reg;
    assign byte_ch.out_byte    = out_byte_reg;
    assign byte_ch.last_of_run = out_last_reg;

endmodule

/* hdl/huffman_code_bit_packer_core.sv */
// Top level of the table-driven Huffman bit packer
//
//  channel     dir  payload                                    transaction
//  symbol_ch   in   mode, symbol, code_word, code_length       valid && ready
//  byte_ch     out  out_byte, last_of_run                      valid && ready
//
// Takes one item per cycle while every code adds at most one byte; the packer
// emits one byte per cycle when not stalled, so a multi-byte code holds input back.
// First byte passes in turn through table read, queue, pack and output registers.
// Reset clears the table's loaded flags at once; no clearing pass is needed.
// A stalled output fills the queue, then drops ready on symbol_ch.
module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    hcbp_in_if.sink     symbol_ch,
    hcbp_out_if.source  byte_ch
);
    import hcbp_pkg::*;

    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int ENTRY_W = 1 + LEN_W + MAX_CODE_LEN;

    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic               pop;
    logic               head_valid;
    logic [ENTRY_W-1:0] head_entry;
    hcbp_qstat_t        qstat;

    // Accept and look up
    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol_ch  (symbol_ch),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple lookup from packing
    hcbp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_entry),
        .qstat      (qstat)
    );

    // Pack bits into bytes
    hcbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_code  (head_entry[MAX_CODE_LEN-1:0]),
        .head_len   (head_entry[MAX_CODE_LEN+LEN_W-1:MAX_CODE_LEN]),
        .head_last  (head_entry[ENTRY_W-1]),
        .pop        (pop),
        .byte_ch    (byte_ch)
    );

endmodule

/* hdl/hcbp_checker.sv */
// Port-level checker for the Huffman bit packer, bound to the top level
`include "huffman_code_bit_packer_core_assert.svh"

module hcbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // A stalled byte holds until taken
    `HCBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_run), "stalled output byte changed")

    // No byte can be ready in the first cycle out of reset
    `HCBP_ASSERT_IMPLY(a_no_early_out, clk, rst_n, $past(!rst_n), !out_valid, "output valid right after reset")

    // An empty queue takes items as soon as reset ends
    `HCBP_ASSERT_IMPLY(a_ready_after_reset, clk, rst_n, $past(!rst_n), in_ready, "input not ready after reset")

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (symbol_ch.ready),
    .out_valid   (byte_ch.valid),
    .out_ready   (byte_ch.ready),
    .out_byte    (byte_ch.out_byte),
    .last_of_run (byte_ch.last_of_run)
);
